@@ src/depq_pkg.sv @@
package depq_pkg;

  localparam int unsigned CAPACITY    = 256;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned ENTRY_W     = 9;
  localparam int unsigned CNT_W       = $clog2(CAPACITY + 1);
  localparam int unsigned GROUP_SIZE  = 16;
  localparam int unsigned NUM_GROUPS  = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_POP_MAX = 2'd1,
    REQ_POP_MIN = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP_MAX,
    CELL_POP_MIN,
    CELL_CLEAR
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TREE,
    ST_OUT
  } state_e;

  // broadcast to every cell
  typedef struct packed {
    cell_op_e                 op;
    logic signed [VAL_W-1:0]  ins_val;
  } cell_ctrl_t;

  // what a cell shows its neighbours
  typedef struct packed {
    logic                     vld;
    logic                     go;   // new value lands here or further left
    logic signed [VAL_W-1:0]  val;
  } nbr_t;

endpackage

@@ src/double_ended_priority_queue_unit.sv @@
// Double-ended priority queue of signed 32-bit values held as an ascending chain of cells.
// Each request transaction inserts a value, removes the largest, removes the smallest or
// clears the queue, and yields exactly one result transaction with the empty flag, the
// count, the maximum, the minimum (both zero when empty) and a flag for an insert dropped
// on a full queue. Removals on an empty queue leave it unchanged. For each request, the
// accepting edge shifts the whole cell chain at once, the next edge registers the first
// level of the maximum reduction tree (groups of sixteen cells), and the output register
// then loads once the previous result has been taken. The next request is accepted once
// that load is done, so a result may wait at the output while the next request is worked.
// No clearing pass is needed after reset: every cell has its own valid flag.
module double_ended_priority_queue_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        req_type_i,
  input  logic signed [depq_pkg::VAL_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              is_empty_o,
  output logic [depq_pkg::ENTRY_W-1:0]      entry_count_o,
  output logic signed [depq_pkg::VAL_W-1:0] max_value_o,
  output logic signed [depq_pkg::VAL_W-1:0] min_value_o,
  output logic                              full_drop_o
);

  depq_pkg::state_e              state_q, state_d;
  logic [depq_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic                          drop_q, drop_d;
  logic                          out_vld_q, out_vld_d;
  logic                          in_acc, out_load, full;
  depq_pkg::cell_ctrl_t          ctrl;
  depq_pkg::nbr_t                cells [depq_pkg::CAPACITY];
  logic [depq_pkg::VAL_W-1:0]    taps  [depq_pkg::CAPACITY];
  logic [depq_pkg::CAPACITY-1:0] vld_vec;
  logic [depq_pkg::VAL_W-1:0]    tree_max;
  logic [depq_pkg::CNT_W+depq_pkg::ENTRY_W-1:0] cnt_ext;

  logic                              is_empty_q;
  logic [depq_pkg::ENTRY_W-1:0]      entry_count_q;
  logic signed [depq_pkg::VAL_W-1:0] max_value_q, min_value_q;
  logic                              full_drop_q;

  assign full       = (cnt_q == depq_pkg::CNT_W'(depq_pkg::CAPACITY));
  assign in_ready_o = (state_q == depq_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == depq_pkg::ST_OUT) && (!out_vld_q || out_ready_i);

  // Request decode: the chain only moves on the accepting edge.
  always_comb begin
    ctrl.ins_val = value_i;
    ctrl.op      = depq_pkg::CELL_HOLD;
    cnt_d        = cnt_q;
    drop_d       = drop_q;
    if (in_acc) begin
      drop_d = 1'b0;
      case (depq_pkg::req_e'(req_type_i))
        depq_pkg::REQ_INSERT: begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            ctrl.op = depq_pkg::CELL_INSERT;
            cnt_d   = cnt_q + 1'b1;
          end
        end
        depq_pkg::REQ_POP_MAX: begin
          if (cnt_q != '0) begin
            ctrl.op = depq_pkg::CELL_POP_MAX;
            cnt_d   = cnt_q - 1'b1;
          end
        end
        depq_pkg::REQ_POP_MIN: begin
          if (cnt_q != '0) begin
            ctrl.op = depq_pkg::CELL_POP_MIN;
            cnt_d   = cnt_q - 1'b1;
          end
        end
        depq_pkg::REQ_CLEAR: begin
          ctrl.op = depq_pkg::CELL_CLEAR;
          cnt_d   = '0;
        end
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    out_vld_d = out_vld_q;
    if (out_vld_q && out_ready_i) out_vld_d = 1'b0;
    case (state_q)
      depq_pkg::ST_IDLE: if (in_acc) state_d = depq_pkg::ST_TREE;
      depq_pkg::ST_TREE: state_d = depq_pkg::ST_OUT;
      depq_pkg::ST_OUT: begin
        if (out_load) begin
          state_d   = depq_pkg::ST_IDLE;
          out_vld_d = 1'b1;
        end
      end
      default: state_d = depq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= depq_pkg::ST_IDLE;
      cnt_q     <= '0;
      drop_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      drop_q    <= drop_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Cell chain: cell 0 holds the minimum; ends see fixed boundary neighbours.
  for (genvar i = 0; i < depq_pkg::CAPACITY; i++) begin : g_cell
    depq_pkg::nbr_t left_n, right_n;
    if (i == 0) begin : g_first
      assign left_n = '{vld: 1'b1, go: 1'b0, val: '0};
    end else begin : g_mid_l
      assign left_n = cells[i-1];
    end
    if (i == depq_pkg::CAPACITY - 1) begin : g_last
      assign right_n = '{vld: 1'b0, go: 1'b1, val: '0};
    end else begin : g_mid_r
      assign right_n = cells[i+1];
    end

    depq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .left_i  (left_n),
      .right_i (right_n),
      .self_o  (cells[i]),
      .tap_o   (taps[i])
    );

    assign vld_vec[i] = cells[i].vld;
  end

  depq_max_tree u_max_tree (
    .clk_i (clk_i),
    .tap_i (taps),
    .max_o (tree_max)
  );

  assign cnt_ext = {depq_pkg::ENTRY_W'(0), cnt_q};

  // Output register: payload loads only with a fresh result.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      is_empty_q    <= (cnt_q == '0);
      entry_count_q <= cnt_ext[depq_pkg::ENTRY_W-1:0];
      max_value_q   <= tree_max;
      min_value_q   <= cells[0].vld ? cells[0].val : '0;
      full_drop_q   <= drop_q;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign is_empty_o    = is_empty_q;
  assign entry_count_o = entry_count_q;
  assign max_value_o   = max_value_q;
  assign min_value_o   = min_value_q;
  assign full_drop_o   = full_drop_q;

  // Valid flags always form a prefix whose length matches the count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld_vec) == cnt_q)
    else $error("cell valid flags disagree with held count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) == !cells[0].vld)
    else $error("bottom cell validity disagrees with empty count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !is_empty_q |-> max_value_q >= min_value_q)
    else $error("reported maximum below reported minimum");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == depq_pkg::ST_TREE && !in_ready_o)
    else $error("request taken while a transaction is in flight");

endmodule

@@ src/depq_cell.sv @@
module depq_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  depq_pkg::cell_ctrl_t ctrl_i,
  input  depq_pkg::nbr_t       left_i,
  input  depq_pkg::nbr_t       right_i,
  output depq_pkg::nbr_t       self_o,
  output logic [depq_pkg::VAL_W-1:0] tap_o
);

  logic                              vld_q, vld_d;
  logic signed [depq_pkg::VAL_W-1:0] val_q, val_d;
  logic                              go;

  assign go = !vld_q || (ctrl_i.ins_val < val_q);

  always_comb begin
    vld_d = vld_q;
    val_d = val_q;
    case (ctrl_i.op)
      depq_pkg::CELL_INSERT: begin
        if (go) begin
          val_d = left_i.go ? left_i.val : ctrl_i.ins_val;
          vld_d = vld_q | left_i.vld;
        end
      end
      depq_pkg::CELL_POP_MAX: vld_d = vld_q & right_i.vld;
      depq_pkg::CELL_POP_MIN: begin
        val_d = right_i.val;
        vld_d = right_i.vld;
      end
      depq_pkg::CELL_CLEAR: vld_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign self_o = '{vld: vld_q, go: go, val: val_q};
  // only the topmost valid cell contributes to the max reduction
  assign tap_o  = (vld_q && !right_i.vld) ? val_q : '0;

endmodule

@@ src/depq_max_tree.sv @@
module depq_max_tree (
  input  logic                        clk_i,
  input  logic [depq_pkg::VAL_W-1:0]  tap_i [depq_pkg::CAPACITY],
  output logic [depq_pkg::VAL_W-1:0]  max_o
);

  logic [depq_pkg::VAL_W-1:0] grp_q [depq_pkg::NUM_GROUPS];
  logic [depq_pkg::VAL_W-1:0] grp_d [depq_pkg::NUM_GROUPS];

  // at most one tap is non-zero, so OR acts as a one-hot select
  always_comb begin
    for (int g = 0; g < depq_pkg::NUM_GROUPS; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < depq_pkg::GROUP_SIZE; k++) begin
        if (g * depq_pkg::GROUP_SIZE + k < depq_pkg::CAPACITY) begin
          grp_d[g] = grp_d[g] | tap_i[g * depq_pkg::GROUP_SIZE + k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  always_comb begin
    max_o = '0;
    for (int g = 0; g < depq_pkg::NUM_GROUPS; g++) begin
      max_o = max_o | grp_q[g];
    end
  end

endmodule
